// ===== design/gsq_pkg.sv =====
// Shared types and constants for the gas sensor query block.
// Used by gsq_front, gsq_queue, gsq_back and gas_sensor_query_fsm.
`timescale 1ns / 1ps
`default_nettype none
package gsq_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int FC_W        = $clog2(FRAME_BYTES + 1);
  localparam int FB_IDX_W    = $clog2(FRAME_BYTES);
  localparam int PARSE_BYTES = 13;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CMD_LEN   = 9;
  localparam int BEAT_W    = $clog2(CMD_LEN);
  localparam int JOB_DATA_W = 48;

  localparam logic [7:0] BYTE_START   = 8'hFF;
  localparam logic [7:0] BYTE_ADDR    = 8'h01;
  localparam logic [7:0] BYTE_READ    = 8'h87;
  localparam logic [7:0] BYTE_SETMODE = 8'h78;
  localparam logic [7:0] BYTE_INFO    = 8'hD1;
  localparam logic [7:0] BYTE_READ_CS = 8'h78;

  localparam logic [7:0] RETRY_RST = 8'd5;
  localparam logic [7:0] LIMIT_RST = 8'd5;
  localparam logic [7:0] MODE_RST  = 8'h41;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_BYTE  = 3'd1,
    REQ_INIT  = 3'd2,
    REQ_ACQ   = 3'd3,
    REQ_QUERY = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    PH_UNINIT = 2'd0,
    PH_IDLE   = 2'd1,
    PH_INFO   = 2'd2,
    PH_ACQ    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_RETRY = 2'd0,
    CFG_LIMIT = 2'd1,
    CFG_MODE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_MEAS   = 2'd1,
    KIND_INFO   = 2'd2,
    KIND_GIVEUP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    JOB_INIT   = 3'd0,
    JOB_READ   = 3'd1,
    JOB_QUERY  = 3'd2,
    JOB_MEAS   = 3'd3,
    JOB_SINFO  = 3'd4,
    JOB_GIVEUP = 3'd5
  } job_code_t;

  typedef struct packed {
    job_code_t               code;
    logic [JOB_DATA_W-1:0]   data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== design/gsq_front.sv =====
// Front end: accepts items, holds phase, tick count, frame store and config.
// Classifies each item and pushes jobs to the queue. Depends on gsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsq_front import gsq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_rx_frame_end,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire q_stat_t     q_stat,
  output logic             push,
  output job_t             push_job
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [7:0]  residue_r, residue_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;
  logic        frdy_r, frdy_nxt;
  logic [7:0]  sum8_r, sum8_nxt;
  logic [7:0]  sum12_r, sum12_nxt;
  logic [7:0]  store_r [FRAME_BYTES];
  logic        wr_en;

  logic [7:0]  retry_r, limit_r, mode_r;

  logic        mod_busy_r;
  logic [2:0]  mod_step_r;
  logic [7:0]  rem_r, rem_new;
  logic [8:0]  rem_t;

  logic        acc;
  logic [7:0]  period;
  logic [7:0]  tick_inc;
  logic [8:0]  res_inc;
  logic [7:0]  res_adv;
  logic [7:0]  fb [PARSE_BYTES];
  logic        good_meas, good_info;

  assign in_ready = !q_stat.full && !mod_busy_r;
  assign acc      = in_valid && in_ready;
  assign period   = (retry_r == 8'd0) ? 8'd1 : retry_r;

  always_comb begin
    rem_t = {rem_r, tick_r[mod_step_r]};
    if (rem_t >= {1'b0, period}) begin
      rem_new = 8'(rem_t - {1'b0, period});
    end else begin
      rem_new = rem_t[7:0];
    end
  end

  always_comb begin
    for (int i = 0; i < PARSE_BYTES; i++) begin
      fb[i] = (fc_r > FC_W'(i)) ? store_r[i] : 8'h00;
    end
  end

  assign good_meas = (fb[0] == BYTE_START) && (fb[1] == BYTE_READ) && (fb[12] == sum12_r);
  assign good_info = (fb[8] == sum8_r);

  assign tick_inc = tick_r + 8'd1;
  assign res_inc  = {1'b0, residue_r} + 9'd1;
  assign res_adv  = (tick_inc == 8'd0 || res_inc == {1'b0, period}) ? 8'd0 : res_inc[7:0];

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    residue_nxt = residue_r;
    fc_nxt      = fc_r;
    frdy_nxt    = frdy_r;
    sum8_nxt    = sum8_r;
    sum12_nxt   = sum12_r;
    wr_en       = 1'b0;
    push        = 1'b0;
    push_job    = '{code: JOB_GIVEUP, data: '0};
    if (mod_busy_r && mod_step_r == 3'd0) begin
      residue_nxt = rem_new;
    end
    if (acc) begin
      unique case (in_req_type)
        REQ_TICK: begin
          if (phase_r == PH_INFO || phase_r == PH_ACQ) begin
            tick_nxt = tick_inc;
            if (frdy_r) begin
              fc_nxt      = '0;
              frdy_nxt    = 1'b0;
              sum8_nxt    = 8'd0;
              sum12_nxt   = 8'd0;
              residue_nxt = res_adv;
              if (phase_r == PH_ACQ && good_meas) begin
                push     = 1'b1;
                push_job = '{code: JOB_MEAS,
                             data: {fb[6], fb[7], fb[8], fb[9], fb[10], fb[11]}};
              end else if (phase_r == PH_INFO && good_info) begin
                push     = 1'b1;
                push_job = '{code: JOB_SINFO,
                             data: {8'h00, fb[0], fb[1], fb[2], fb[3], fb[7]}};
              end
              if (push) begin
                tick_nxt    = 8'd0;
                residue_nxt = 8'd0;
                phase_nxt   = PH_IDLE;
              end
            end else if (res_adv == 8'd0) begin
              residue_nxt = 8'd0;
              push        = 1'b1;
              push_job    = '{code: (phase_r == PH_ACQ) ? JOB_READ : JOB_QUERY, data: '0};
            end else if (tick_inc > limit_r) begin
              push        = 1'b1;
              push_job    = '{code: JOB_GIVEUP, data: '0};
              tick_nxt    = 8'd0;
              residue_nxt = 8'd0;
              phase_nxt   = PH_IDLE;
            end else begin
              residue_nxt = res_adv;
            end
          end
        end
        REQ_BYTE: begin
          if (!frdy_r) begin
            if (fc_r < FC_W'(FRAME_BYTES)) begin
              wr_en  = 1'b1;
              fc_nxt = fc_r + FC_W'(1);
              if (fc_r < FC_W'(8)) begin
                sum8_nxt = sum8_r + in_rx_byte;
              end
              if (fc_r < FC_W'(12)) begin
                sum12_nxt = sum12_r + in_rx_byte;
              end
            end
            if (in_rx_frame_end) begin
              frdy_nxt = 1'b1;
            end
          end
        end
        REQ_INIT: begin
          if (phase_r == PH_UNINIT) begin
            push      = 1'b1;
            push_job  = '{code: JOB_INIT, data: JOB_DATA_W'(mode_r)};
            phase_nxt = PH_IDLE;
          end
        end
        REQ_ACQ: begin
          if (phase_r == PH_IDLE) begin
            push      = 1'b1;
            push_job  = '{code: JOB_READ, data: '0};
            phase_nxt = PH_ACQ;
          end
        end
        REQ_QUERY: begin
          if (phase_r == PH_IDLE) begin
            push      = 1'b1;
            push_job  = '{code: JOB_QUERY, data: '0};
            phase_nxt = PH_INFO;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_UNINIT;
      tick_r     <= 8'd0;
      residue_r  <= 8'd0;
      fc_r       <= '0;
      frdy_r     <= 1'b0;
      sum8_r     <= 8'd0;
      sum12_r    <= 8'd0;
      retry_r    <= RETRY_RST;
      limit_r    <= LIMIT_RST;
      mode_r     <= MODE_RST;
      mod_busy_r <= 1'b0;
      mod_step_r <= 3'd0;
      rem_r      <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      residue_r <= residue_nxt;
      fc_r      <= fc_nxt;
      frdy_r    <= frdy_nxt;
      sum8_r    <= sum8_nxt;
      sum12_r   <= sum12_nxt;
      if (cfg_valid && cfg_index == CFG_RETRY) begin
        mod_busy_r <= 1'b1;
        mod_step_r <= 3'd7;
        rem_r      <= 8'd0;
      end else if (mod_busy_r) begin
        rem_r      <= rem_new;
        mod_step_r <= mod_step_r - 3'd1;
        if (mod_step_r == 3'd0) begin
          mod_busy_r <= 1'b0;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_RETRY: retry_r <= cfg_data;
          CFG_LIMIT: limit_r <= cfg_data;
          CFG_MODE:  mode_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[fc_r[FB_IDX_W-1:0]] <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== design/gsq_queue.sv =====
// Job queue between front and back ends.
// Small register FIFO of job_t entries. Depends on gsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsq_queue import gsq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head,
  output q_stat_t    q_stat
);

  job_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push, do_pop;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== design/gsq_back.sv =====
// Back end: expands queued jobs into output beats through an output register.
// Init and read jobs become byte bursts; query and result jobs one beat. Depends on gsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsq_back import gsq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire job_t         head,
  input  wire q_stat_t      q_stat,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_tx_byte,
  output logic              out_tx_last,
  output logic [15:0]       out_concentration,
  output logic signed [15:0] out_temperature_centi,
  output logic [15:0]       out_humidity_centi,
  output logic [7:0]        out_sensor_kind,
  output logic [15:0]       out_full_range,
  output logic [7:0]        out_unit_code,
  output logic [7:0]        out_sign_code
);

  logic              out_valid_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        txb_r, txb_nxt;
  logic              txl_r, txl_nxt;
  logic [47:0]       data_r, data_nxt;
  logic [BEAT_W-1:0] beat_r;
  logic [BEAT_W-1:0] last_beat;
  logic              gen;
  logic [7:0]        mode;

  assign gen  = !q_stat.empty && (!out_valid_r || out_ready);
  assign mode = head.data[7:0];

  always_comb begin
    kind_nxt  = KIND_TX;
    txb_nxt   = 8'h00;
    data_nxt  = '0;
    last_beat = '0;
    unique case (head.code)
      JOB_INIT: begin
        last_beat = BEAT_W'(CMD_LEN - 1);
        case (beat_r)
          BEAT_W'(0): txb_nxt = BYTE_START;
          BEAT_W'(1): txb_nxt = BYTE_ADDR;
          BEAT_W'(2): txb_nxt = BYTE_SETMODE;
          BEAT_W'(3): txb_nxt = mode;
          BEAT_W'(8): txb_nxt = BYTE_SETMODE + mode;
          default:    txb_nxt = 8'h00;
        endcase
      end
      JOB_READ: begin
        last_beat = BEAT_W'(CMD_LEN - 1);
        case (beat_r)
          BEAT_W'(0): txb_nxt = BYTE_START;
          BEAT_W'(1): txb_nxt = BYTE_ADDR;
          BEAT_W'(2): txb_nxt = BYTE_READ;
          BEAT_W'(8): txb_nxt = BYTE_READ_CS;
          default:    txb_nxt = 8'h00;
        endcase
      end
      JOB_QUERY: txb_nxt = BYTE_INFO;
      JOB_MEAS: begin
        kind_nxt = KIND_MEAS;
        data_nxt = head.data;
      end
      JOB_SINFO: begin
        kind_nxt = KIND_INFO;
        data_nxt = head.data;
      end
      JOB_GIVEUP: kind_nxt = KIND_GIVEUP;
      default: kind_nxt = KIND_GIVEUP;
    endcase
    txl_nxt = (kind_nxt == KIND_TX) && (beat_r == last_beat);
  end

  assign pop = gen && (beat_r == last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      if (gen) begin
        out_valid_r <= 1'b1;
        beat_r      <= (beat_r == last_beat) ? '0 : beat_r + BEAT_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      kind_r <= kind_nxt;
      txb_r  <= txb_nxt;
      txl_r  <= txl_nxt;
      data_r <= data_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = kind_r;
  assign out_tx_byte           = txb_r;
  assign out_tx_last           = txl_r;
  assign out_concentration     = (kind_r == KIND_MEAS) ? data_r[47:32] : 16'h0000;
  assign out_temperature_centi = (kind_r == KIND_MEAS) ? $signed(data_r[31:16]) : 16'sh0000;
  assign out_humidity_centi    = (kind_r == KIND_MEAS) ? data_r[15:0] : 16'h0000;
  assign out_sensor_kind       = (kind_r == KIND_INFO) ? data_r[39:32] : 8'h00;
  assign out_full_range        = (kind_r == KIND_INFO) ? data_r[31:16] : 16'h0000;
  assign out_unit_code         = (kind_r == KIND_INFO) ? data_r[15:8] : 8'h00;
  assign out_sign_code         = (kind_r == KIND_INFO) ? data_r[7:0] : 8'h00;

endmodule
`default_nettype wire

// ===== design/gas_sensor_query_fsm.sv =====
// Gas sensor query block: 1 item per cycle accepted while the 4-entry job queue
// has room and no retry_period write is being handled (serial residue update).
// A result passes the job queue and the output register before it shows on
// out_valid. The back end emits 1 beat per cycle while out_ready allows it.
// Synchronous active-low reset clears phase, counters, queue and out_valid;
// frame store contents are not cleared. Depends on gsq_pkg, gsq_front/queue/back.
`timescale 1ns / 1ps
`default_nettype none
module gas_sensor_query_fsm import gsq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_req_type,
  input  wire logic [7:0]   in_rx_byte,
  input  wire logic         in_rx_frame_end,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_tx_byte,
  output logic              out_tx_last,
  output logic [15:0]       out_concentration,
  output logic signed [15:0] out_temperature_centi,
  output logic [15:0]       out_humidity_centi,
  output logic [7:0]        out_sensor_kind,
  output logic [15:0]       out_full_range,
  output logic [7:0]        out_unit_code,
  output logic [7:0]        out_sign_code,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  job_t    push_job, head;

  assign cfg_ready = 1'b1;

  gsq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_rx_byte      (in_rx_byte),
    .in_rx_frame_end (in_rx_frame_end),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_stat          (q_stat),
    .push            (q_push),
    .push_job        (push_job)
  );

  gsq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gsq_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .q_stat                (q_stat),
    .pop                   (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_tx_byte           (out_tx_byte),
    .out_tx_last           (out_tx_last),
    .out_concentration     (out_concentration),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_sensor_kind       (out_sensor_kind),
    .out_full_range        (out_full_range),
    .out_unit_code         (out_unit_code),
    .out_sign_code         (out_sign_code)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_beat_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty && !out_valid |=> !out_valid)
    else $error("beat produced without a queued job");

endmodule
`default_nettype wire

// ===== dv/tb_gas_sensor_query_fsm.sv =====
// Self-checking bench for gas_sensor_query_fsm: commands, frame parsing, retry and give-up.
// A local model of the host exchange predicts every out beat. Depends on gsq_pkg and gas_sensor_query_fsm.
`timescale 1ns / 1ps
module tb_gas_sensor_query_fsm;
  import gsq_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 8;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          DRAIN_LIMIT   = 1000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          LONG_HOLD     = 100;
  localparam int          MAX_REPORTS   = 10;
  localparam int          REQ_CODES     = 8;
  localparam logic [2:0]  REQ_UNUSED    = 3'd7;
  localparam int          MEAS_CS_AT    = PARSE_BYTES - 1;
  localparam int          INFO_CS_AT    = 8;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] rx_byte;
    logic       rx_end;
  } host_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] conc;
    logic [15:0] temp_c;
    logic [15:0] hum_c;
    logic [7:0]  skind;
    logic [15:0] frange;
    logic [7:0]  unit_c;
    logic [7:0]  sign_c;
  } host_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_req_type = REQ_TICK;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              in_rx_frame_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [7:0]        out_tx_byte;
  logic              out_tx_last;
  logic [15:0]       out_concentration;
  logic signed [15:0] out_temperature_centi;
  logic [15:0]       out_humidity_centi;
  logic [7:0]        out_sensor_kind;
  logic [15:0]       out_full_range;
  logic [7:0]        out_unit_code;
  logic [7:0]        out_sign_code;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_RETRY;
  logic [7:0]        cfg_data = 8'h00;

  host_req_t  req_q[$];
  host_beat_t owed_q[$];
  int         errors = 0;
  logic       idling = 1'b1;
  logic       squeeze_req = 1'b0;
  logic       in_took = 1'b0;

  // host exchange model state
  logic [7:0] retry_cfg = RETRY_RST;
  logic [7:0] limit_cfg = LIMIT_RST;
  logic [7:0] mode_cfg = MODE_RST;
  phase_t     ph = PH_UNINIT;
  logic [7:0] ticks = 8'd0;
  logic [7:0] fstore [FRAME_BYTES];
  int         fcount = 0;
  logic       fready = 1'b0;

  gas_sensor_query_fsm dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] byte_sum(input logic [7:0] q[$]);
    logic [7:0] s;
    s = 8'h00;
    foreach (q[i]) s = s + q[i];
    return s;
  endfunction

  function automatic logic [7:0] fb(input int i);
    return (i < fcount) ? fstore[i] : 8'h00;
  endfunction

  function automatic logic [7:0] frame_sum(input int n);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < n; i++) s = s + fb(i);
    return s;
  endfunction

  function automatic string beat_str(input host_beat_t b);
    return $sformatf({"kind=%0d tx=%h last=%b conc=%h temp=%h hum=%h ",
                      "type=%h range=%h unit=%h sign=%h"},
                     b.kind, b.tx_byte, b.tx_last, b.conc, b.temp_c, b.hum_c, b.skind,
                     b.frange, b.unit_c, b.sign_c);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic owe_bytes(input logic [7:0] cmd[$]);
    host_beat_t r;
    foreach (cmd[i]) begin
      r = '0;
      r.kind = KIND_TX;
      r.tx_byte = cmd[i];
      r.tx_last = (i == cmd.size() - 1);
      owed_q.push_back(r);
    end
  endtask

  task automatic owe_resend();
    logic [7:0] cmd[$];
    if (ph == PH_ACQ) begin
      cmd.push_back(BYTE_START);
      cmd.push_back(BYTE_ADDR);
      cmd.push_back(BYTE_READ);
      repeat (5) cmd.push_back(8'h00);
      cmd.push_back(BYTE_READ_CS);
    end else begin
      cmd.push_back(BYTE_INFO);
    end
    owe_bytes(cmd);
  endtask

  task automatic host_tick();
    host_beat_t r;
    logic       good;
    int         period;
    period = (retry_cfg == 8'd0) ? 1 : int'(retry_cfg);
    ticks = ticks + 8'd1;
    r = '0;
    if (fready) begin
      if (ph == PH_ACQ) begin
        good = fb(0) == BYTE_START && fb(1) == BYTE_READ &&
               fb(MEAS_CS_AT) == frame_sum(MEAS_CS_AT);
        r.kind = KIND_MEAS;
        r.conc = {fb(6), fb(7)};
        r.temp_c = {fb(8), fb(9)};
        r.hum_c = {fb(10), fb(11)};
      end else begin
        good = fb(INFO_CS_AT) == frame_sum(INFO_CS_AT);
        r.kind = KIND_INFO;
        r.skind = fb(0);
        r.frange = {fb(1), fb(2)};
        r.unit_c = fb(3);
        r.sign_c = fb(7);
      end
      fcount = 0;
      fready = 1'b0;
      if (good) begin
        owed_q.push_back(r);
        ticks = 8'd0;
        ph = PH_IDLE;
      end
    end else if (int'(ticks) % period == 0) begin
      owe_resend();
    end else if (ticks > limit_cfg) begin
      r.kind = KIND_GIVEUP;
      owed_q.push_back(r);
      ticks = 8'd0;
      ph = PH_IDLE;
    end
  endtask

  task automatic compute_host_output(input logic [2:0] req, input logic [7:0] b,
                                     input logic e);
    logic [7:0] cmd[$];
    case (req)
      REQ_TICK: if (ph == PH_INFO || ph == PH_ACQ) host_tick();
      REQ_BYTE: if (!fready) begin
        if (fcount < FRAME_BYTES) begin
          fstore[fcount] = b;
          fcount++;
        end
        if (e) fready = 1'b1;
      end
      REQ_INIT: if (ph == PH_UNINIT) begin
        cmd.push_back(BYTE_START);
        cmd.push_back(BYTE_ADDR);
        cmd.push_back(BYTE_SETMODE);
        cmd.push_back(mode_cfg);
        repeat (4) cmd.push_back(8'h00);
        cmd.push_back(byte_sum(cmd));
        owe_bytes(cmd);
        ph = PH_IDLE;
      end
      REQ_ACQ: if (ph == PH_IDLE) begin
        ph = PH_ACQ;
        owe_resend();
      end
      REQ_QUERY: if (ph == PH_IDLE) begin
        ph = PH_INFO;
        owe_resend();
      end
      default: ;
    endcase
  endtask

  // monitor: configuration, requests, result beats
  always @(posedge clk) begin : watch_ports
    host_beat_t got;
    host_beat_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RETRY: retry_cfg = cfg_data;
          CFG_LIMIT: limit_cfg = cfg_data;
          CFG_MODE:  mode_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) compute_host_output(in_req_type, in_rx_byte, in_rx_frame_end);
      if (out_valid && out_ready) begin
        got = host_beat_t'({out_kind, out_tx_byte, out_tx_last, out_concentration,
                            out_temperature_centi, out_humidity_centi, out_sensor_kind,
                            out_full_range, out_unit_code, out_sign_code});
        if (owed_q.size() == 0) begin
          flag_error({"unexpected beat ", beat_str(got)});
        end else begin
          want = owed_q.pop_front();
          if (got !== want)
            flag_error({"beat mismatch\n  want ", beat_str(want), "\n  got  ", beat_str(got)});
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin : drive_reqs
    host_req_t it;
    int        gap;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        it = req_q.pop_front();
        in_valid <= 1'b1;
        in_req_type <= it.req;
        in_rx_byte <= it.rx_byte;
        in_rx_frame_end <= it.rx_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver; hold off once for a long stretch to back up the block
  always @(negedge clk) begin : drive_out_ready
    int  hold;
    bit  squeezed;
    if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else if (squeeze_req && !squeezed) begin
      squeezed = 1'b1;
      hold = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_item(input logic [2:0] req, input logic [7:0] b, input logic e);
    host_req_t it;
    it.req = req;
    it.rx_byte = b;
    it.rx_end = e;
    req_q.push_back(it);
  endtask

  task automatic push_plain(input logic [2:0] req);
    push_item(req, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_frame(input logic [7:0] fr[$]);
    foreach (fr[i]) push_item(REQ_BYTE, fr[i], i == fr.size() - 1);
  endtask

  task automatic add_random_frame(input bit meas, input bit clean);
    logic [7:0] fr[$];
    int         n;
    int         j;
    int         mangle;
    n = meas ? PARSE_BYTES : INFO_CS_AT + 1;
    repeat (n - 1) fr.push_back(8'($urandom_range(0, 255)));
    if (meas) begin
      fr[0] = BYTE_START;
      fr[1] = BYTE_READ;
    end
    fr.push_back(byte_sum(fr));
    mangle = clean ? -1 : $urandom_range(0, 9);
    case (mangle)
      0: begin
        j = $urandom_range(0, n - 1);
        fr[j] = fr[j] ^ (8'h01 << $urandom_range(0, 7));
      end
      1: repeat ($urandom_range(1, n - 1)) void'(fr.pop_back());
      2: repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    push_frame(fr);
    // trailing bytes after the frame end must be dropped
    if (mangle == 3) repeat ($urandom_range(1, 3)) push_plain(REQ_BYTE);
  endtask

  task automatic add_session();
    int  k;
    bit  meas;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      repeat ($urandom_range(1, 3)) push_plain(3'($urandom_range(0, REQ_CODES - 1)));
    end else begin
      meas = (k < 6);
      push_plain(meas ? REQ_ACQ : REQ_QUERY);
      repeat ($urandom_range(0, 3)) push_plain(REQ_TICK);
      add_random_frame(meas, 1'b0);
      repeat ($urandom_range(1, 2)) push_plain(REQ_TICK);
    end
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (req_q.size() != 0 || in_valid || owed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] fr[$];
    logic [7:0] seed_meas [MEAS_CS_AT];
    int         i;
    seed_meas = '{BYTE_START, BYTE_READ, 8'h00, 8'hFF, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_MODE, 8'hFF);
    // full measurement frame first so every parsed byte slot has been written
    foreach (seed_meas[k]) fr.push_back(seed_meas[k]);
    fr.push_back(byte_sum(fr));
    push_frame(fr);
    push_plain(REQ_INIT);
    push_plain(REQ_INIT);
    push_item(REQ_UNUSED, 8'hFF, 1'b1);
    push_plain(REQ_TICK);
    push_plain(REQ_ACQ);
    push_plain(REQ_TICK);
    push_plain(REQ_QUERY);
    repeat (6) push_plain(REQ_TICK);
    settle();

    // resend on every tick, never give up; back up the block
    cfg_write(CFG_RETRY, 8'd0);
    cfg_write(CFG_LIMIT, 8'd0);
    idling = 1'b0;
    repeat (3) add_session();
    squeeze_req = 1'b1;
    settle();

    // wrap the tick count
    cfg_write(CFG_RETRY, 8'd255);
    cfg_write(CFG_LIMIT, 8'd255);
    cfg_write(CFG_MODE, 8'h00);
    idling = 1'b1;
    push_plain(REQ_QUERY);
    push_plain(REQ_TICK);
    push_plain(REQ_QUERY);
    repeat (260) push_plain(REQ_TICK);
    add_random_frame(1'b0, 1'b1);
    push_plain(REQ_TICK);
    settle();

    cfg_write(CFG_RETRY, 8'($urandom_range(2, 6)));
    cfg_write(CFG_LIMIT, 8'($urandom_range(3, 12)));
    repeat (2) add_session();
    settle();

    cfg_write(CFG_RETRY, 8'($urandom_range(1, 4)));
    cfg_write(CFG_LIMIT, 8'($urandom_range(0, 8)));
    cfg_write(CFG_MODE, 8'($urandom_range(0, 255)));
    idling = 1'b0;
    repeat (2) add_session();

    do @(posedge clk); while (req_q.size() != 0 || in_valid);
    for (i = 0; i < DRAIN_LIMIT && owed_q.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_q.size() != 0)
      flag_error($sformatf("%0d beats never arrived", owed_q.size()));
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
